>>> design/b64t_pkg.sv
package b64t_pkg;

	// Token geometry
	localparam int TokenChars = 22;
	localparam int TokenBits  = 128;
	localparam int AccBits    = 126;
	localparam int CountBits  = 5;

	// Operation codes
	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	// Result kinds
	typedef enum logic {
		KIND_CHAR    = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	// ASCII anchors of the URL alphabet
	localparam logic [7:0] ChUpperA = 8'h41;
	localparam logic [7:0] ChUpperZ = 8'h5A;
	localparam logic [7:0] ChLowerA = 8'h61;
	localparam logic [7:0] ChLowerZ = 8'h7A;
	localparam logic [7:0] ChDigit0 = 8'h30;
	localparam logic [7:0] ChDigit9 = 8'h39;
	localparam logic [7:0] ChMinus  = 8'h2D;
	localparam logic [7:0] ChUnder  = 8'h5F;

	typedef struct packed {
		op_t                operation;
		logic signed [63:0] timestamp_in;
		logic        [63:0] id_in;
		logic        [7:0]  char_in;
		logic               char_last;
	} in_item_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [7:0]  char_out;
		logic        last_out;
		logic        decode_ok;
		logic [62:0] timestamp_out;
		logic [63:0] id_out;
	} out_item_t;

	typedef struct packed {
		logic        busy;
		logic        last;
		logic [7:0]  char_out;
	} enc_status_t;

	typedef struct packed {
		logic        ok;
		logic [62:0] timestamp;
		logic [63:0] id;
	} verdict_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} sextet_t;

	// Map an ASCII byte to its six-bit value
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t s;
		s.valid = 1'b1;
		s.value = 6'd0;
		if (c >= ChUpperA && c <= ChUpperZ) begin
			s.value = 6'(c - ChUpperA);
		end else if (c >= ChLowerA && c <= ChLowerZ) begin
			s.value = 6'(c - ChLowerA) + 6'd26;
		end else if (c >= ChDigit0 && c <= ChDigit9) begin
			s.value = 6'(c - ChDigit0) + 6'd52;
		end else if (c == ChMinus) begin
			s.value = 6'd62;
		end else if (c == ChUnder) begin
			s.value = 6'd63;
		end else begin
			s.valid = 1'b0;
		end
		return s;
	endfunction

	// Map a six-bit value to its ASCII character
	function automatic logic [7:0] char_of(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = ChUpperA + {2'b00, v};
		end else if (v < 6'd52) begin
			c = ChLowerA + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			c = ChDigit0 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			c = ChMinus;
		end else begin
			c = ChUnder;
		end
		return c;
	endfunction

endpackage

>>> design/b64t_if.sv
interface b64t_in_if;
	logic                valid;
	logic                ready;
	b64t_pkg::in_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface b64t_out_if;
	logic                valid;
	logic                ready;
	b64t_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> design/b64t_encoder.sv
module b64t_encoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [127:0]              token,
	input  logic                      emit,
	output b64t_pkg::enc_status_t     status
);
	import b64t_pkg::*;

	logic [TokenBits-1:0] shift_q;
	logic [CountBits-1:0] left_q;

	// Shift the token out six bits per character, zeros fill the tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			left_q <= CountBits'(TokenChars);
		end else if (emit) begin
			left_q <= left_q - CountBits'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= token;
		end else if (emit) begin
			shift_q <= {shift_q[TokenBits-7:0], 6'd0};
		end
	end

	assign status.busy     = (left_q != '0);
	assign status.last     = (left_q == CountBits'(1));
	assign status.char_out = char_of(shift_q[TokenBits-1 -: 6]);

endmodule

>>> design/b64t_decoder.sv
module b64t_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            char_in,
	input  logic                  char_last,
	output b64t_pkg::verdict_t    verdict
);
	import b64t_pkg::*;

	logic [AccBits-1:0]   acc_q;
	logic [CountBits-1:0] count_q;
	logic                 bad_q;
	sextet_t              sx;
	logic [63:0]          ts;
	logic [63:0]          id;
	logic                 ok;

	assign sx = sextet_of(char_in);

	// Accumulate characters; clear everything after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			count_q <= '0;
			bad_q   <= 1'b0;
		end else if (step) begin
			if (char_last) begin
				acc_q   <= '0;
				count_q <= '0;
				bad_q   <= 1'b0;
			end else begin
				if (count_q < CountBits'(TokenChars - 1)) begin
					acc_q <= {acc_q[AccBits-7:0], sx.value};
				end
				if (count_q != '1) begin
					count_q <= count_q + CountBits'(1);
				end
				bad_q <= bad_q | ~sx.valid;
			end
		end
	end

	// Check the token formed with the last character
	assign ts = acc_q[AccBits-1 -: 64];
	assign id = {acc_q[61:0], sx.value[5:4]};
	assign ok = (count_q == CountBits'(TokenChars - 1)) && !bad_q && sx.valid
		&& (ts != '0) && !ts[63] && (id != '0);

	assign verdict.ok        = ok;
	assign verdict.timestamp = ok ? ts[62:0] : '0;
	assign verdict.id        = ok ? id : '0;

endmodule

>>> design/base64url_token_codec.sv
// Channel   Role    Payload
// cmd       sink    operation, timestamp_in, id_in, char_in, char_last
// res       source  result_kind, char_out, last_out, decode_ok, timestamp_out, id_out
//
// A decode character is accepted every cycle unless an encode item or a final character is held waiting.
// An encode item yields 22 characters, one per cycle unless res stalls, from the encoder shift register;
// the next encode item loads on the cycle the last character leaves.
// A verdict leaves once the encoder burst ahead of it is done.
// Reset clears the decode state, the burst counter and both valid flags.
// A stall on res holds the result register; encode items and last decode characters wait in the input register.
module base64url_token_codec (
	input  logic clk,
	input  logic arst_n,
	b64t_in_if.sink    cmd,
	b64t_out_if.source res
);
	import b64t_pkg::*;

	logic        s1_valid_q;
	in_item_t    item_s1;
	logic        out_valid_q;
	out_item_t   out_q;
	logic        out_free;
	logic        s1_adv;
	logic        enc_emit;
	logic        enc_avail;
	logic        enc_load;
	logic        dec_step;
	logic        verdict_go;
	enc_status_t enc_st;
	verdict_t    verdict;

	assign out_free  = !out_valid_q || res.ready;
	assign enc_emit  = enc_st.busy && out_free;
	assign enc_avail = !enc_st.busy || (enc_emit && enc_st.last);

	// Decide whether the held item moves on this cycle
	always_comb begin
		s1_adv = 1'b0;
		if (s1_valid_q) begin
			if (item_s1.operation == OP_ENCODE) begin
				s1_adv = enc_avail;
			end else if (item_s1.char_last) begin
				s1_adv = !enc_st.busy && out_free;
			end else begin
				s1_adv = 1'b1;
			end
		end
	end

	assign enc_load   = s1_adv && (item_s1.operation == OP_ENCODE);
	assign dec_step   = s1_adv && (item_s1.operation == OP_DECODE);
	assign verdict_go = dec_step && item_s1.char_last;
	assign cmd.ready  = !s1_valid_q || s1_adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= cmd.payload;
		end
	end

	b64t_encoder u_enc (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (enc_load),
		.token  ({item_s1.timestamp_in, item_s1.id_in}),
		.emit   (enc_emit),
		.status (enc_st)
	);

	b64t_decoder u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (dec_step),
		.char_in   (item_s1.char_in),
		.char_last (item_s1.char_last),
		.verdict   (verdict)
	);

	// Result register: encoder characters first, then verdicts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (enc_emit || verdict_go) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (enc_emit) begin
			out_q.result_kind   <= KIND_CHAR;
			out_q.char_out      <= enc_st.char_out;
			out_q.last_out      <= enc_st.last;
			out_q.decode_ok     <= 1'b0;
			out_q.timestamp_out <= '0;
			out_q.id_out        <= '0;
		end else if (verdict_go) begin
			out_q.result_kind   <= KIND_VERDICT;
			out_q.char_out      <= '0;
			out_q.last_out      <= 1'b1;
			out_q.decode_ok     <= verdict.ok;
			out_q.timestamp_out <= verdict.timestamp;
			out_q.id_out        <= verdict.id;
		end
	end

	assign res.valid   = out_valid_q;
	assign res.payload = out_q;

endmodule

>>> design/b64t_checker.sv
module b64t_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input b64t_pkg::out_item_t res_payload
);
	import b64t_pkg::*;

	// Hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_payload))
		else $error("result changed while stalled");

	// Close every verdict and zero the fields of a failed one
	a_verdict_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_payload.result_kind == KIND_VERDICT |->
			res_payload.last_out && res_payload.char_out == 8'd0 &&
			(res_payload.decode_ok ||
			 (res_payload.timestamp_out == '0 && res_payload.id_out == '0)))
		else $error("malformed verdict");

	// Accept only nonzero values in a good verdict
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_payload.result_kind == KIND_VERDICT && res_payload.decode_ok |->
			res_payload.timestamp_out != '0 && res_payload.id_out != '0)
		else $error("good verdict with zero field");

	// Emit only URL alphabet characters
	a_char_alphabet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_payload.result_kind == KIND_CHAR |->
			(res_payload.char_out >= ChUpperA && res_payload.char_out <= ChUpperZ) ||
			(res_payload.char_out >= ChLowerA && res_payload.char_out <= ChLowerZ) ||
			(res_payload.char_out >= ChDigit0 && res_payload.char_out <= ChDigit9) ||
			res_payload.char_out == ChMinus || res_payload.char_out == ChUnder)
		else $error("encoded character outside alphabet");

endmodule

bind base64url_token_codec b64t_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_payload (res.payload)
);
